/* rtl/xts_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xts_pkg
// Shared types, codes and helpers of the XML token scanner.
// ----------------------------------------------------------------------------
package xts_pkg;

    localparam int MAX_RES = 4;
    localparam int NAME_W  = 6;
    localparam int VALUE_W = 12;

    // Token kinds
    typedef enum logic [2:0] {
        K_BEGIN = 3'd0,
        K_END   = 3'd1,
        K_ATTR  = 3'd2,
        K_TEXT  = 3'd3,
        K_OTHER = 3'd4
    } kind_t;

    // Result events
    typedef enum logic [2:0] {
        EV_START = 3'd0,
        EV_NAME  = 3'd1,
        EV_SPLIT = 3'd2,
        EV_VALUE = 3'd3,
        EV_STOP  = 3'd4,
        EV_ERROR = 3'd5
    } ev_t;

    // Error codes
    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_NAME_LEN = 3'd1,
        ERR_SLASH    = 3'd2,
        ERR_EARLY    = 3'd3,
        ERR_TRUNC    = 3'd4
    } err_t;

    // Configuration register indexes
    localparam logic CFG_NAME_LIMIT  = 1'b0;
    localparam logic CFG_VALUE_LIMIT = 1'b1;

    // Scanner states
    typedef enum logic [15:0] {
        S_IDLE       = 16'h0001,
        S_DONE       = 16'h0002,
        S_LT         = 16'h0004,
        S_SLASH      = 16'h0008,
        S_BEGIN_NAME = 16'h0010,
        S_END_NAME   = 16'h0020,
        S_ATTR_NAME  = 16'h0040,
        S_ATTR_EQ    = 16'h0080,
        S_ATTR_VAL   = 16'h0100,
        S_ATTR_DROP  = 16'h0200,
        S_TEXT       = 16'h0400,
        S_TEXT_DROP  = 16'h0800,
        S_COMMENT    = 16'h1000,
        S_PI         = 16'h2000,
        S_BANG       = 16'h4000,
        S_DECL       = 16'h8000
    } state_t;

    // Characters of interest
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_QMARK = 8'h3F;

    typedef struct packed {
        kind_t      kind;
        ev_t        ev;
        logic [7:0] ch;
        err_t       code;
    } res_t;

    // Results caused by one byte
    typedef struct packed {
        res_t [MAX_RES-1:0] item;
        logic [2:0]         cnt;
    } batch_t;

    function automatic res_t mk_res(kind_t k, ev_t e, logic [7:0] c, err_t code);
        res_t r;
        r.kind = k;
        r.ev   = e;
        r.ch   = c;
        r.code = code;
        return r;
    endfunction

    // Append one result; a full batch drops it
    function automatic batch_t push(batch_t b, res_t r);
        batch_t o;
        o = b;
        if (b.cnt < 3'(MAX_RES))
        begin
            o.item[b.cnt[1:0]] = r;
            o.cnt              = b.cnt + 3'd1;
        end
        return o;
    endfunction

endpackage

/* rtl/xml_token_scanner.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xml_token_scanner
// Path: a byte is registered on acceptance, tagged combinationally by the core,
// and its results are registered in the result buffer. Throughput: one byte
// per cycle while m_tready is high and each byte gives at most one result;
// a byte with more results holds the single output port until all are taken.
// Reset: rst_n clears the scanner to between tokens, empties both
// registers and restores the limits to NAME_MAX and VALUE_MAX.
// ----------------------------------------------------------------------------
module xml_token_scanner
    import xts_pkg::*;
#(
    parameter int NAME_MAX  = 30,
    parameter int VALUE_MAX = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // end_of_buffer
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] char_out, [10:8] error_code, zero above
    output logic [5:0]  m_tuser,   // [2:0] token_kind, [5:3] event_res
    output logic        m_tlast,   // last
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [11:0] cfg_data
);

    logic                in_valid_reg;
    logic [7:0]          in_byte_reg;
    logic                in_eob_reg;
    logic [NAME_W-1:0]   name_limit_reg;
    logic [VALUE_W-1:0]  value_limit_reg;
    logic                buf_free;
    logic                take;
    batch_t              batch;
    res_t                res;

    assign take      = in_valid_reg && buf_free;
    assign s_tready  = !in_valid_reg || take;
    assign cfg_ready = 1'b1;

    // Register the incoming byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_eob_reg  <= s_tlast;
        end
    end

    // Limit registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            name_limit_reg  <= NAME_W'(NAME_MAX);
            value_limit_reg <= VALUE_W'(VALUE_MAX);
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_NAME_LIMIT)
                name_limit_reg <= cfg_data[NAME_W-1:0];
            else if (cfg_index == CFG_VALUE_LIMIT)
                value_limit_reg <= cfg_data;
        end
    end

    xts_scan_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (take),
        .data_byte     (in_byte_reg),
        .end_of_buffer (in_eob_reg),
        .name_limit    (name_limit_reg),
        .value_limit   (value_limit_reg),
        .batch         (batch)
    );

    xts_result_buf u_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (take),
        .batch    (batch),
        .free     (buf_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_res    (res),
        .m_last   (m_tlast)
    );

    // Pack the result fields
    assign m_tdata = {5'd0, res.code, res.ch};
    assign m_tuser = {res.ev, res.kind};

endmodule

/* rtl/xts_scan_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xts_scan_core
// Scanner state and the single-pass logic that tags one byte.
// ----------------------------------------------------------------------------
module xts_scan_core
    import xts_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               take,
    input  logic [7:0]         data_byte,
    input  logic               end_of_buffer,
    input  logic [NAME_W-1:0]  name_limit,
    input  logic [VALUE_W-1:0] value_limit,
    output batch_t             batch
);

    state_t              st_reg,   st_next;
    kind_t               kind_reg, kind_next;
    logic [NAME_W-1:0]   seg_reg,  seg_next;
    logic [VALUE_W-1:0]  vcnt_reg, vcnt_next;
    logic                ns_reg,   ns_next;
    logic [1:0]          dash_reg, dash_next;

    // Work out the next state and the results for one byte
    always_comb
    begin
        logic [7:0] b;
        logic       fatal;
        logic       do_bname;
        logic       do_idle;
        logic       do_split;
        logic       do_name;
        logic       do_value;
        state_t     drop_st;
        kind_t      sk;
        state_t     sn;
        batch_t     bt;

        b         = data_byte;
        st_next   = st_reg;
        kind_next = kind_reg;
        seg_next  = seg_reg;
        vcnt_next = vcnt_reg;
        ns_next   = ns_reg;
        dash_next = dash_reg;
        fatal     = 1'b0;
        do_bname  = 1'b0;
        do_idle   = 1'b0;
        do_split  = 1'b0;
        do_name   = 1'b0;
        do_value  = 1'b0;
        drop_st   = S_TEXT_DROP;
        sk        = K_BEGIN;
        sn        = S_BEGIN_NAME;
        bt        = '0;

        unique case (st_reg)
            S_IDLE:
            begin
                do_idle = 1'b1;
            end
            S_DONE:
            begin
            end
            S_LT:
            begin
                if (b == CH_SLASH)
                begin
                    sk = K_END;
                    sn = S_END_NAME;
                end
                else if (b == CH_QMARK)
                begin
                    sk        = K_OTHER;
                    sn        = S_PI;
                    dash_next = 2'd1;
                end
                else if (b == CH_BANG)
                begin
                    sk        = K_OTHER;
                    sn        = S_BANG;
                    dash_next = 2'd0;
                end
                else
                begin
                    do_bname = 1'b1;
                end
                kind_next = sk;
                seg_next  = '0;
                ns_next   = 1'b0;
                vcnt_next = '0;
                st_next   = sn;
                bt        = push(bt, mk_res(kind_next, EV_START, 8'd0, ERR_NONE));
            end
            S_SLASH:
            begin
                if (b == CH_GT)
                begin
                    kind_next = K_END;
                    seg_next  = '0;
                    ns_next   = 1'b0;
                    vcnt_next = '0;
                    bt        = push(bt, mk_res(kind_next, EV_START, 8'd0, ERR_NONE));
                    bt        = push(bt, mk_res(kind_next, EV_STOP, 8'd0, ERR_NONE));
                    st_next   = S_IDLE;
                    do_idle   = 1'b1;
                end
                else
                begin
                    bt      = push(bt, mk_res(kind_next, EV_ERROR, 8'd0, ERR_SLASH));
                    fatal   = 1'b1;
                    st_next = S_DONE;
                end
            end
            S_BEGIN_NAME:
            begin
                do_bname = 1'b1;
            end
            S_END_NAME:
            begin
                if (b == CH_GT)
                begin
                    bt      = push(bt, mk_res(kind_next, EV_STOP, 8'd0, ERR_NONE));
                    st_next = S_IDLE;
                    do_idle = 1'b1;
                end
                else if (b == CH_COLON && !ns_next)
                    do_split = 1'b1;
                else
                    do_name = 1'b1;
            end
            S_ATTR_NAME:
            begin
                if (b == CH_EQ)
                begin
                    vcnt_next = '0;
                    st_next   = S_ATTR_EQ;
                end
                else if (b == CH_COLON && !ns_next)
                    do_split = 1'b1;
                else
                    do_name = 1'b1;
            end
            S_ATTR_EQ:
            begin
                st_next = S_ATTR_VAL;
                if (b == CH_QUOTE)
                begin
                end
                else if (b == CH_SP)
                begin
                    bt      = push(bt, mk_res(kind_next, EV_STOP, 8'd0, ERR_NONE));
                    st_next = S_IDLE;
                end
                else
                begin
                    do_value = 1'b1;
                    drop_st  = S_ATTR_DROP;
                end
            end
            S_ATTR_VAL, S_ATTR_DROP:
            begin
                if (b == CH_QUOTE || b == CH_SP)
                begin
                    bt      = push(bt, mk_res(kind_next, EV_STOP, 8'd0, ERR_NONE));
                    st_next = S_IDLE;
                end
                else if (st_reg == S_ATTR_VAL)
                begin
                    do_value = 1'b1;
                    drop_st  = S_ATTR_DROP;
                end
            end
            S_TEXT, S_TEXT_DROP:
            begin
                if (b == CH_LT)
                begin
                    bt        = push(bt, mk_res(kind_next, EV_STOP, 8'd0, ERR_NONE));
                    kind_next = K_BEGIN;
                    st_next   = S_LT;
                end
                else if (st_reg == S_TEXT)
                begin
                    do_value = 1'b1;
                    drop_st  = S_TEXT_DROP;
                end
            end
            S_COMMENT:
            begin
                if (b == CH_GT && dash_reg >= 2'd2)
                begin
                    bt      = push(bt, mk_res(kind_next, EV_STOP, 8'd0, ERR_NONE));
                    st_next = S_IDLE;
                    do_idle = 1'b1;
                end
                else if (b == CH_DASH)
                    dash_next = (dash_reg >= 2'd2) ? 2'd2 : dash_reg + 2'd1;
                else
                    dash_next = 2'd0;
            end
            S_PI:
            begin
                if (b == CH_GT && dash_reg == 2'd1)
                begin
                    bt      = push(bt, mk_res(kind_next, EV_STOP, 8'd0, ERR_NONE));
                    st_next = S_IDLE;
                    do_idle = 1'b1;
                end
                else
                    dash_next = {1'b0, b == CH_QMARK};
            end
            S_BANG:
            begin
                if (b == CH_DASH)
                begin
                    if (dash_reg >= 2'd1)
                    begin
                        dash_next = 2'd2;
                        st_next   = S_COMMENT;
                    end
                    else
                        dash_next = dash_reg + 2'd1;
                end
                else if (b == CH_GT)
                begin
                    bt      = push(bt, mk_res(kind_next, EV_STOP, 8'd0, ERR_NONE));
                    st_next = S_IDLE;
                    do_idle = 1'b1;
                end
                else
                    st_next = S_DECL;
            end
            S_DECL:
            begin
                if (b == CH_GT)
                begin
                    bt      = push(bt, mk_res(kind_next, EV_STOP, 8'd0, ERR_NONE));
                    st_next = S_IDLE;
                    do_idle = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        // Element name byte: close on space, '>' or '/'
        if (do_bname)
        begin
            if (b == CH_SP || b == CH_GT || b == CH_SLASH)
            begin
                bt      = push(bt, mk_res(kind_next, EV_STOP, 8'd0, ERR_NONE));
                st_next = S_IDLE;
                do_idle = 1'b1;
            end
            else if (b == CH_COLON && !ns_next)
                do_split = 1'b1;
            else
                do_name = 1'b1;
        end

        // Byte between tokens
        if (do_idle)
        begin
            if (b == CH_SP || b == CH_CR || b == CH_LF)
            begin
            end
            else if (b == CH_NUL)
                st_next = S_DONE;
            else if ((b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A))
            begin
                kind_next = K_ATTR;
                seg_next  = '0;
                ns_next   = 1'b0;
                vcnt_next = '0;
                st_next   = S_ATTR_NAME;
                bt        = push(bt, mk_res(kind_next, EV_START, 8'd0, ERR_NONE));
                do_name   = 1'b1;
            end
            else if (b == CH_LT)
            begin
                kind_next = K_BEGIN;
                st_next   = S_LT;
            end
            else if (b == CH_SLASH)
            begin
                kind_next = K_END;
                st_next   = S_SLASH;
            end
            else
            begin
                kind_next = (b == CH_GT) ? K_TEXT : K_OTHER;
                seg_next  = '0;
                ns_next   = 1'b0;
                vcnt_next = '0;
                st_next   = (b == CH_GT) ? S_TEXT : S_IDLE;
                bt        = push(bt, mk_res(kind_next, EV_START, 8'd0, ERR_NONE));
                if (b != CH_GT)
                    bt = push(bt, mk_res(kind_next, EV_STOP, 8'd0, ERR_NONE));
            end
        end

        // Namespace split
        if (do_split)
        begin
            bt       = push(bt, mk_res(kind_next, EV_SPLIT, 8'd0, ERR_NONE));
            ns_next  = 1'b1;
            seg_next = '0;
        end

        // Name character against the segment limit
        if (do_name)
        begin
            if (seg_next >= name_limit)
            begin
                bt      = push(bt, mk_res(kind_next, EV_ERROR, 8'd0, ERR_NAME_LEN));
                fatal   = 1'b1;
                st_next = S_DONE;
            end
            else
            begin
                bt       = push(bt, mk_res(kind_next, EV_NAME, b, ERR_NONE));
                seg_next = seg_next + 6'd1;
            end
        end

        // Value character against the value limit
        if (do_value)
        begin
            if (vcnt_next >= value_limit)
            begin
                bt      = push(bt, mk_res(kind_next, EV_ERROR, 8'd0, ERR_TRUNC));
                st_next = drop_st;
            end
            else
            begin
                bt        = push(bt, mk_res(kind_next, EV_VALUE, b, ERR_NONE));
                vcnt_next = vcnt_next + 12'd1;
            end
        end

        // Buffer end closes any open token
        if (end_of_buffer)
        begin
            if (!fatal && st_next != S_IDLE && st_next != S_DONE)
                bt = push(bt, mk_res(kind_next, EV_ERROR, 8'd0, ERR_EARLY));
            st_next = S_IDLE;
        end

        batch = bt;
    end

    // Advance the scanner state on each taken byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= S_IDLE;
            kind_reg <= K_BEGIN;
            seg_reg  <= '0;
            vcnt_reg <= '0;
            ns_reg   <= 1'b0;
            dash_reg <= 2'd0;
        end
        else if (take)
        begin
            st_reg   <= st_next;
            kind_reg <= kind_next;
            seg_reg  <= seg_next;
            vcnt_reg <= vcnt_next;
            ns_reg   <= ns_next;
            dash_reg <= dash_next;
        end
    end

    // A fatal error always parks the scanner until buffer end; this checks the name length case
    a_name_err_done: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !end_of_buffer && batch.cnt != 3'd0
         && batch.item[0].code == ERR_NAME_LEN && batch.cnt == 3'd1 && st_reg != S_IDLE)
        |=> (st_reg == S_DONE))
        else $error("name length error did not stop the scanner");

    a_eob_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (take && end_of_buffer) |=> (st_reg == S_IDLE))
        else $error("scanner not idle after buffer end");

    a_dash_range: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_COMMENT) |-> (dash_reg <= 2'd2))
        else $error("dash count out of range in comment");

endmodule

/* rtl/xts_result_buf.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xts_result_buf
// Holds the results of one byte and hands them out one per cycle while m_tready is high.
// ----------------------------------------------------------------------------
module xts_result_buf
    import xts_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   load,
    input  batch_t batch,
    output logic   free,
    output logic   m_tvalid,
    input  logic   m_tready,
    output res_t   m_res,
    output logic   m_last
);

    res_t [MAX_RES-1:0] item_reg;
    logic [2:0]         cnt_reg;
    logic [1:0]         idx_reg;
    logic               at_last;

    assign at_last  = ({1'b0, idx_reg} == (cnt_reg - 3'd1));
    assign m_tvalid = (cnt_reg != 3'd0);
    assign m_res    = item_reg[idx_reg];
    assign m_last   = at_last;
    assign free     = (cnt_reg == 3'd0) || (m_tready && at_last);

    // Hold result payload
    always_ff @(posedge clk)
    begin
        if (load)
            item_reg <= batch.item;
    end

    // Load a new batch or step to the next request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 3'd0;
            idx_reg <= 2'd0;
        end
        else if (load)
        begin
            cnt_reg <= batch.cnt;
            idx_reg <= 2'd0;
        end
        else if (m_tvalid && m_tready)
        begin
            if (at_last)
            begin
                cnt_reg <= 3'd0;
                idx_reg <= 2'd0;
            end
            else
                idx_reg <= idx_reg + 2'd1;
        end
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 3'(MAX_RES))
        else $error("result count above capacity");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ({1'b0, idx_reg} < cnt_reg))
        else $error("result index past count");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (cnt_reg == 3'd0 || (m_tready && at_last)))
        else $error("batch loaded over pending results");

endmodule
